FILE: hw/rtl/calclk_pkg.sv
package calclk_pkg;

  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_SET_DATE = 2'd1;
  localparam logic [1:0] REQ_SET_TIME = 2'd2;

  localparam logic REG_TWELVE_HOUR = 1'b0;

  localparam logic [13:0] YEAR_LAST   = 14'd9999;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [4:0]  HOUR_NOON   = 5'd12;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [5:0]  SECOND_LAST = 6'd59;

  localparam logic [13:0] YEAR_RST   = 14'd2021;
  localparam logic [3:0]  MONTH_RST  = 4'd4;
  localparam logic [4:0]  DAY_RST    = 5'd28;
  localparam logic [4:0]  HOUR_RST   = 5'd23;
  localparam logic [5:0]  MINUTE_RST = 6'd32;
  localparam logic [5:0]  SECOND_RST = 6'd3;

  // y divisible by 25 iff (y * 25^-1 mod 2^14) <= (2^14 - 1) / 25
  localparam logic [13:0] INV25       = 14'd7209;
  localparam logic [13:0] DIV25_LIMIT = 14'd655;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] load_year;
    logic [6:0]  load_month;
    logic [6:0]  load_day;
    logic [6:0]  load_hour;
    logic [6:0]  load_minute;
    logic [6:0]  load_second;
  } calclk_item_t;

  typedef struct packed {
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [4:0]  shown_hour;
    logic        pm_flag;
    logic        set_rejected;
  } calclk_result_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        by25;
    prod = y * INV25;
    by25 = (prod <= DIV25_LIMIT);
    return ((y[1:0] == 2'd0) && !by25) || ((y[3:0] == 4'd0) && by25);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hw/rtl/calendar_clock_counter.sv
// Calendar clock counter: one tick, set-date or set-time beat per cycle unless a
// result beat waits on result_ready. The result beat, registered, follows in the
// cycle after acceptance; the next-state logic is a single compare/increment
// cascade plus two 14-bit constant leap-year multiplies feeding the registers.
// Reset (synchronous, active high): 2021-04-28 23:32:03, 24-hour view, no result pending.
module calendar_clock_counter
  import calclk_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  calclk_item_t   item,
  output logic           result_valid,
  input  logic           result_ready,
  output calclk_result_t result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic        twelve_hour_mode;
  logic [13:0] year, year_next;
  logic [3:0]  month, month_next;
  logic [4:0]  day, day_next;
  logic [4:0]  hour, hour_next;
  logic [5:0]  minute, minute_next;
  logic [5:0]  second, second_next;
  logic        rejected;
  logic        accept;
  logic        date_ok;
  logic        time_ok;
  logic [4:0]  cur_len;
  logic [4:0]  new_len;
  calclk_result_t result_next;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TWELVE_HOUR) ? {31'd0, twelve_hour_mode} : 32'd0;

  assign cur_len = month_len(is_leap(year), month);
  assign new_len = month_len(is_leap(item.load_year), item.load_month[3:0]);

  assign date_ok = (item.load_year <= YEAR_LAST) && (item.load_month >= 7'd1) &&
                   (item.load_month <= {3'd0, MONTH_LAST}) && (item.load_day >= 7'd1) &&
                   (item.load_day <= {2'd0, new_len});
  assign time_ok = (item.load_hour <= {2'd0, HOUR_LAST}) &&
                   (item.load_minute <= {1'd0, MINUTE_LAST}) &&
                   (item.load_second <= {1'd0, SECOND_LAST});

  always_comb begin
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    rejected    = 1'b0;
    unique case (item.req_type)
      REQ_TICK: begin
        if (second != SECOND_LAST) begin
          second_next = second + 6'd1;
        end else begin
          second_next = 6'd0;
          if (minute != MINUTE_LAST) begin
            minute_next = minute + 6'd1;
          end else begin
            minute_next = 6'd0;
            if (hour != HOUR_LAST) begin
              hour_next = hour + 5'd1;
            end else begin
              hour_next = 5'd0;
              if (day < cur_len) begin
                day_next = day + 5'd1;
              end else begin
                day_next = 5'd1;
                if (month < MONTH_LAST) begin
                  month_next = month + 4'd1;
                end else begin
                  month_next = 4'd1;
                  year_next  = (year >= YEAR_LAST) ? 14'd0 : year + 14'd1;
                end
              end
            end
          end
        end
      end
      REQ_SET_DATE: begin
        if (date_ok) begin
          year_next  = item.load_year;
          month_next = item.load_month[3:0];
          day_next   = item.load_day[4:0];
        end else begin
          rejected = 1'b1;
        end
      end
      REQ_SET_TIME: begin
        if (time_ok) begin
          hour_next   = item.load_hour[4:0];
          minute_next = item.load_minute[5:0];
          second_next = item.load_second[5:0];
        end else begin
          rejected = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_next.cur_year     = year_next;
    result_next.cur_month    = month_next;
    result_next.cur_day      = day_next;
    result_next.cur_hour     = hour_next;
    result_next.cur_minute   = minute_next;
    result_next.cur_second   = second_next;
    result_next.set_rejected = rejected;
    if (twelve_hour_mode) begin
      result_next.pm_flag = (hour_next >= HOUR_NOON);
      if (hour_next == 5'd0) begin
        result_next.shown_hour = HOUR_NOON;
      end else if (hour_next > HOUR_NOON) begin
        result_next.shown_hour = hour_next - HOUR_NOON;
      end else begin
        result_next.shown_hour = hour_next;
      end
    end else begin
      result_next.pm_flag    = 1'b0;
      result_next.shown_hour = hour_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      twelve_hour_mode <= 1'b0;
      year             <= YEAR_RST;
      month            <= MONTH_RST;
      day              <= DAY_RST;
      hour             <= HOUR_RST;
      minute           <= MINUTE_RST;
      second           <= SECOND_RST;
      result_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_TWELVE_HOUR)) begin
        twelve_hour_mode <= pwdata[0];
      end
      if (accept) begin
        year         <= year_next;
        month        <= month_next;
        day          <= day_next;
        hour         <= hour_next;
        minute       <= minute_next;
        second       <= second_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_result_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.cur_year <= YEAR_LAST) && (result.cur_month >= 4'd1) &&
      (result.cur_month <= MONTH_LAST) && (result.cur_day >= 5'd1) &&
      (result.cur_hour <= HOUR_LAST) && (result.cur_minute <= MINUTE_LAST) &&
      (result.cur_second <= SECOND_LAST))
    else $error("result beat holds an illegal date or time");

  a_result_mirrors_state: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.cur_year == year) && (result.cur_month == month) &&
      (result.cur_day == day) && (result.cur_hour == hour) &&
      (result.cur_minute == minute) && (result.cur_second == second))
    else $error("pending result differs from the clock state");

  a_pm_after_noon: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.pm_flag) |-> (result.cur_hour >= HOUR_NOON))
    else $error("pm flag set before noon");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.req_type == REQ_TICK) && (second != SECOND_LAST))
      |=> (second == $past(second) + 6'd1))
    else $error("tick did not advance seconds");
`endif

endmodule
